/* hdl/nlp_pkg.sv */
package nlp_pkg;

  localparam int HIST_LEN = 5;
  localparam int IDX_W = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;

  localparam logic [63:0] WEIGHT_INIT = 64'd28147497671066;
  localparam logic [47:0] RATE_INIT = 48'd281474977;
  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_ESTIMATE = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] slot;
    logic [31:0] sample_value;
    logic signed [31:0] prediction_error;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] estimate_value;
    logic update_skipped;
  } out_res_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

  function automatic logic [IDX_W-1:0] slot_mod(input logic [2:0] s);
    logic [4:0] v;
    v = {2'b00, s};
    for (int k = 0; k < 8; k++) begin
      if (v >= 5'(HIST_LEN)) v = v - 5'(HIST_LEN);
    end
    return IDX_W'(v);
  endfunction

endpackage

/* hdl/nlp_mul.sv */
module nlp_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= {32'b0, a} * {32'b0, b};
  end
endmodule

/* hdl/nlp_div.sv */
module nlp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [63:0]        dividend,
  input  logic [63:0]        divisor,
  output logic               done_r,
  output logic [63:0]        quot_r
);
  logic [64:0] rem_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [64:0] rem_sh;

  assign rem_sh = {rem_r[63:0], quot_r[63]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd64;
        rem_r  <= '0;
        quot_r <= dividend;
      end else if (busy_r) begin
        if (rem_sh >= {1'b0, divisor}) begin
          rem_r  <= rem_sh - {1'b0, divisor};
          quot_r <= {quot_r[62:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          quot_r <= {quot_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

/* hdl/nlms_load_predictor_unit.sv */
// Normalized-LMS load predictor. One request is taken at a time; in_ready is
// high only while the sequencer is idle. A write stores the sample; an
// estimate accumulates weight times sample over the history slots; an update
// sums the squared samples into the norm, then steps each weight, using the
// bit-serial divider. All products go through one shared 32x32 multiplier.
// The learning rate register may be written only while no request is in
// flight.
module nlms_load_predictor_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  nlp_pkg::in_req_t       in_req,
  output logic                   out_valid,
  input  logic                   out_ready,
  output nlp_pkg::out_res_t      out_res,
  input  logic                   cfg_we,
  input  logic [47:0]            cfg_wdata
);
  import nlp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_E_MUL, S_E_ACC, S_E_FIN, S_N_MUL, S_N_ACC, S_U_CHK, S_U_MUL,
    S_U_DIVS, S_U_WAIT, S_U_PMUL, S_U_PACC, S_U_WR, S_DONE
  } state_t;

  state_t state_r;
  logic [31:0] hist_r [HIST_LEN];
  logic [63:0] wgt_r [HIST_LEN];
  logic [47:0] rate_r;
  logic [IDX_W-1:0] i_r, hidx_r, rd_idx;
  logic [1:0] k_r;
  logic signed [127:0] acc_r;
  logic [127:0] pacc_r;
  logic [63:0] norm_r, q_r;
  logic [31:0] emag_r;
  logic eneg_r;
  out_res_t res_r, out_data_r;
  logic out_valid_r;
  logic [31:0] mul_a, mul_b, x;
  logic [63:0] prod, w, wmag, u;
  logic [127:0] eterm, pterm, amag;
  logic [63:0] qmag;
  logic [31:0] lim, est;
  logic div_done;
  logic [63:0] div_quot;
  div_ctl_t dctl;
  logic [IDX_W-1:0] last;

  assign last = IDX_W'(HIST_LEN - 1);
  assign rd_idx = (state_r == S_E_MUL || state_r == S_E_ACC) ? hidx_r : i_r;
  assign x = hist_r[rd_idx];
  assign w = wgt_r[i_r];
  assign wmag = w[63] ? (~w + 64'd1) : w;
  assign u = w ^ SIGN64;

  always_comb begin
    case (state_r)
      S_E_MUL: begin
        mul_a = k_r[0] ? wmag[63:32] : wmag[31:0];
        mul_b = x;
      end
      S_N_MUL: begin
        mul_a = x;
        mul_b = x;
      end
      S_U_MUL: begin
        mul_a = emag_r;
        mul_b = x;
      end
      S_U_PMUL: begin
        mul_a = k_r[1] ? q_r[63:32] : q_r[31:0];
        mul_b = k_r[0] ? {16'b0, rate_r[47:32]} : rate_r[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  nlp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(prod));

  assign dctl.start = (state_r == S_U_DIVS);
  assign dctl.done = div_done;

  nlp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dctl.start), .dividend(prod),
    .divisor(norm_r), .done_r(div_done), .quot_r(div_quot)
  );

  assign eterm = {64'b0, prod} << (k_r[0] ? 7'd32 : 7'd0);
  assign pterm = {64'b0, prod} << (7'd32 * ({6'b0, k_r[1]} + {6'b0, k_r[0]}));
  assign amag = acc_r[127] ? (~acc_r + 128'd1) : acc_r;
  assign qmag = amag[111:48];
  assign lim = acc_r[127] ? 32'h8000_0000 : 32'h7FFF_FFFF;

  always_comb begin
    if (amag[127:112] != '0 || qmag > {32'b0, lim}) est = lim;
    else est = qmag[31:0];
    if (acc_r[127]) est = ~est + 32'd1;
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      rate_r <= RATE_INIT;
      for (int n = 0; n < HIST_LEN; n++) begin
        hist_r[n] <= '0;
        wgt_r[n] <= WEIGHT_INIT;
      end
    end else begin
      if (cfg_we) rate_r <= cfg_wdata;
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            res_r <= '0;
            i_r <= '0;
            k_r <= '0;
            hidx_r <= slot_mod(in_req.slot);
            eneg_r <= in_req.prediction_error[31];
            emag_r <= in_req.prediction_error[31] ?
                      (~in_req.prediction_error + 32'd1) : in_req.prediction_error;
            acc_r <= '0;
            norm_r <= '0;
            case (in_req.cmd)
              CMD_WRITE: begin
                hist_r[slot_mod(in_req.slot)] <= in_req.sample_value;
                state_r <= S_DONE;
              end
              CMD_ESTIMATE: state_r <= S_E_MUL;
              CMD_UPDATE: state_r <= S_N_MUL;
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_E_MUL: state_r <= S_E_ACC;
        S_E_ACC: begin
          if (w[63]) acc_r <= acc_r - $signed(eterm);
          else acc_r <= acc_r + $signed(eterm);
          if (!k_r[0]) begin
            k_r <= 2'd1;
          end else begin
            k_r <= '0;
            if (i_r == last) begin
              state_r <= S_E_FIN;
            end else begin
              i_r <= i_r + 1'b1;
              hidx_r <= (hidx_r == '0) ? last : hidx_r - 1'b1;
            end
          end
          if (!(k_r[0] && i_r == last)) state_r <= S_E_MUL;
        end
        S_E_FIN: begin
          res_r.estimate_value <= est;
          state_r <= S_DONE;
        end
        S_N_MUL: state_r <= S_N_ACC;
        S_N_ACC: begin
          norm_r <= norm_r + {16'b0, prod[63:16]};
          if (i_r == last) begin
            state_r <= S_U_CHK;
          end else begin
            i_r <= i_r + 1'b1;
            state_r <= S_N_MUL;
          end
        end
        S_U_CHK: begin
          i_r <= '0;
          if (norm_r == '0) begin
            res_r.update_skipped <= 1'b1;
            state_r <= S_DONE;
          end else begin
            state_r <= S_U_MUL;
          end
        end
        S_U_MUL: state_r <= S_U_DIVS;
        S_U_DIVS: state_r <= S_U_WAIT;
        S_U_WAIT: begin
          if (div_done) begin
            q_r <= div_quot;
            k_r <= '0;
            pacc_r <= '0;
            state_r <= S_U_PMUL;
          end
        end
        S_U_PMUL: state_r <= S_U_PACC;
        S_U_PACC: begin
          pacc_r <= pacc_r + pterm;
          k_r <= k_r + 2'd1;
          state_r <= (k_r == 2'd3) ? S_U_WR : S_U_PMUL;
        end
        S_U_WR: begin
          if (!eneg_r) begin
            if (pacc_r[127:64] != '0 || pacc_r[63:0] > ~u) wgt_r[i_r] <= '1 ^ SIGN64;
            else wgt_r[i_r] <= (u + pacc_r[63:0]) ^ SIGN64;
          end else begin
            if (pacc_r[127:64] != '0 || pacc_r[63:0] > u) wgt_r[i_r] <= SIGN64;
            else wgt_r[i_r] <= (u - pacc_r[63:0]) ^ SIGN64;
          end
          if (i_r == last) begin
            state_r <= S_DONE;
          end else begin
            i_r <= i_r + 1'b1;
            state_r <= S_U_MUL;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_data_r <= res_r;
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    dctl.done |-> state_r == S_U_WAIT) else $error("divider done outside wait");

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.update_skipped && out_data_r.estimate_value != 0))
    else $error("skip flag with nonzero estimate");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("accepted while busy");

endmodule
